[hdl/sdfrbi_pkg.sv]
// ----------------------------------------------------------------------------
// sdfrbi_pkg
// Shared types and constants for the structure-data record boundary indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdfrbi_pkg;

  localparam int OFFSET_BITS_DEF      = 32;
  localparam int BLANK_LINE_LIMIT_DEF = 4;

  localparam int COUNT_BITS = 32;
  localparam int RUN_BITS   = 3;

  localparam logic [RUN_BITS-1:0]   MARKER_LEN = RUN_BITS'(4);
  localparam logic [7:0]            NEWLINE    = 8'h0A;
  localparam logic [7:0]            DOLLAR     = 8'h24;
  localparam logic [7:0]            SPACE      = 8'h20;
  localparam logic [7:0]            TAB        = 8'h09;
  localparam logic [7:0]            CR         = 8'h0D;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

  // Input request: one byte of file text.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_req_t;

  // Output request: one confirmed record and/or the end of stream.
  typedef struct packed {
    logic                  has_record;
    logic [COUNT_BITS-1:0] record_offset;
    logic [COUNT_BITS-1:0] record_count;
    logic                  is_end;
  } out_rsp_t;

  // Byte class computed by the front end.
  typedef struct packed {
    logic is_space;
    logic is_newline;
    logic is_dollar;
    logic is_last;
  } byte_class_t;

endpackage

`default_nettype wire

[hdl/sdfrbi_front.sv]
// ----------------------------------------------------------------------------
// sdfrbi_front
// Accepts input bytes, classifies them and tags each with its byte offset.
// ----------------------------------------------------------------------------
`default_nettype none

module sdfrbi_front #(
  parameter int OFFSET_BITS = sdfrbi_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire sdfrbi_pkg::in_req_t    in_data,
  input  wire logic                   q_full,
  output logic                        q_push,
  output sdfrbi_pkg::byte_class_t     q_class,
  output logic [OFFSET_BITS-1:0]      q_pos
);

  logic [OFFSET_BITS-1:0] pos_r;
  logic [OFFSET_BITS-1:0] pos_nxt;
  logic [7:0]             b;

  assign b        = in_data.data_byte;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_pos    = pos_r;

  always_comb begin
    q_class.is_space   = (b == sdfrbi_pkg::SPACE) ||
                         ((b >= sdfrbi_pkg::TAB) && (b <= sdfrbi_pkg::CR));
    q_class.is_newline = (b == sdfrbi_pkg::NEWLINE);
    q_class.is_dollar  = (b == sdfrbi_pkg::DOLLAR);
    q_class.is_last    = in_data.final_byte;
  end

  // Advance the offset once per accepted byte; wrap at the width.
  assign pos_nxt = q_push ? pos_r + OFFSET_BITS'(1) : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/sdfrbi_queue.sv]
// ----------------------------------------------------------------------------
// sdfrbi_queue
// Two-entry queue of classified bytes between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sdfrbi_queue #(
  parameter int OFFSET_BITS = sdfrbi_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire sdfrbi_pkg::byte_class_t   push_class,
  input  wire logic [OFFSET_BITS-1:0]    push_pos,
  output logic                           full,
  input  wire logic                      pop,
  output logic                           q_valid,
  output sdfrbi_pkg::byte_class_t        pop_class,
  output logic [OFFSET_BITS-1:0]         pop_pos
);

  sdfrbi_pkg::byte_class_t class_r [2];
  logic [OFFSET_BITS-1:0]  pos_r   [2];
  logic                    wr_ptr_r, wr_ptr_nxt;
  logic                    rd_ptr_r, rd_ptr_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic                    do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && q_valid;
  assign pop_class = class_r[rd_ptr_r];
  assign pop_pos   = pos_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      class_r[wr_ptr_r] <= push_class;
      pos_r[wr_ptr_r]   <= push_pos;
    end
  end

endmodule

`default_nettype wire

[hdl/sdfrbi_back.sv]
// ----------------------------------------------------------------------------
// sdfrbi_back
// Tracks marker lines and record candidates; registers the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sdfrbi_back #(
  parameter int OFFSET_BITS      = sdfrbi_pkg::OFFSET_BITS_DEF,
  parameter int BLANK_LINE_LIMIT = sdfrbi_pkg::BLANK_LINE_LIMIT_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     q_valid,
  input  wire sdfrbi_pkg::byte_class_t  q_class,
  input  wire logic [OFFSET_BITS-1:0]   q_pos,
  output logic                          q_pop,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output sdfrbi_pkg::out_rsp_t          out_data
);

  localparam int BLANK_W = $clog2(BLANK_LINE_LIMIT + 1);
  localparam logic [BLANK_W:0] LIMIT_V = (BLANK_W + 1)'(BLANK_LINE_LIMIT);

  logic                                    als_r, als_nxt;
  logic [sdfrbi_pkg::RUN_BITS-1:0]         run_r, run_nxt;
  logic [sdfrbi_pkg::RUN_BITS-1:0]         run_inc;
  logic                                    skip_r, skip_nxt;
  logic                                    pend_r, pend_nxt;
  logic [OFFSET_BITS-1:0]                  cand_r, cand_nxt;
  logic [BLANK_W-1:0]                      blank_r, blank_nxt;
  logic [BLANK_W:0]                        blank_inc;
  logic [sdfrbi_pkg::COUNT_BITS-1:0]       recs_r, recs_nxt;
  logic                                    ended_r, ended_nxt;
  logic                                    out_valid_r, out_valid_nxt;
  sdfrbi_pkg::out_rsp_t                    out_data_r, out_data_nxt;

  logic confirmed, ended, work;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign work      = q_pop && !ended_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign blank_inc = {1'b0, blank_r} + (BLANK_W + 1)'(1);
  assign run_inc   = run_r + sdfrbi_pkg::RUN_BITS'(1);

  always_comb begin
    als_nxt       = als_r;
    run_nxt       = run_r;
    skip_nxt      = skip_r;
    pend_nxt      = pend_r;
    cand_nxt      = cand_r;
    blank_nxt     = blank_r;
    recs_nxt      = recs_r;
    ended_nxt     = ended_r;
    confirmed     = 1'b0;
    ended         = 1'b0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (work) begin
      // Candidate sees the byte before any new candidate opens.
      if (pend_r) begin
        if (!q_class.is_space) begin
          pend_nxt  = 1'b0;
          confirmed = 1'b1;
          if (recs_r != sdfrbi_pkg::COUNT_MAX) begin
            recs_nxt = recs_r + sdfrbi_pkg::COUNT_BITS'(1);
          end
        end else if (q_class.is_newline) begin
          blank_nxt = blank_inc[BLANK_W-1:0];
          if (blank_inc >= LIMIT_V) begin
            pend_nxt = 1'b0;
            ended    = 1'b1;
          end
        end
      end

      // Marker line detection.
      if (skip_r) begin
        if (q_class.is_newline) begin
          skip_nxt  = 1'b0;
          als_nxt   = 1'b1;
          run_nxt   = '0;
          pend_nxt  = 1'b1;
          cand_nxt  = q_pos + OFFSET_BITS'(1);
          blank_nxt = '0;
        end
      end else if (q_class.is_newline) begin
        als_nxt = 1'b1;
        run_nxt = '0;
      end else if (als_r && q_class.is_dollar) begin
        run_nxt = run_inc;
        if (run_inc >= sdfrbi_pkg::MARKER_LEN) begin
          skip_nxt = 1'b1;
          als_nxt  = 1'b0;
          run_nxt  = '0;
        end
      end else begin
        als_nxt = 1'b0;
        run_nxt = '0;
      end

      if (q_class.is_last) begin
        ended = 1'b1;
      end
      if (ended) begin
        ended_nxt = 1'b1;
        pend_nxt  = 1'b0;
      end

      if (confirmed || ended) begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.has_record    = confirmed;
        out_data_nxt.record_offset = confirmed ? sdfrbi_pkg::COUNT_BITS'(cand_r) : '0;
        out_data_nxt.record_count  = recs_nxt;
        out_data_nxt.is_end        = ended;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      als_r       <= 1'b1;
      run_r       <= '0;
      skip_r      <= 1'b0;
      pend_r      <= 1'b1;
      cand_r      <= '0;
      blank_r     <= '0;
      recs_r      <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      als_r       <= als_nxt;
      run_r       <= run_nxt;
      skip_r      <= skip_nxt;
      pend_r      <= pend_nxt;
      cand_r      <= cand_nxt;
      blank_r     <= blank_nxt;
      recs_r      <= recs_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

[hdl/sdf_record_boundary_indexer_top.sv]
// Path: an accepted byte is first registered in the queue, then the back end registers
// its result in the output register. Throughput: one byte per cycle while the queue is
// not full; the back end retires one queued byte per cycle whenever the output register is empty or being taken.
// Reset (rst_n low, synchronous): offset counter cleared, queue emptied, line-start
// and candidate-at-offset-0 set, record count cleared, output register empty.
// ----------------------------------------------------------------------------
// sdf_record_boundary_indexer_top
// Scans structure-data file text a byte at a time and reports record starts.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_record_boundary_indexer_top #(
  parameter int OFFSET_BITS      = sdfrbi_pkg::OFFSET_BITS_DEF,
  parameter int BLANK_LINE_LIMIT = sdfrbi_pkg::BLANK_LINE_LIMIT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // byte request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire sdfrbi_pkg::in_req_t   in_data,
  // result request channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output sdfrbi_pkg::out_rsp_t       out_data
);

  // Front end -> queue
  logic                    q_full;
  logic                    q_push;
  sdfrbi_pkg::byte_class_t push_class;
  logic [OFFSET_BITS-1:0]  push_pos;

  // Queue -> back end
  logic                    q_valid;
  logic                    q_pop;
  sdfrbi_pkg::byte_class_t pop_class;
  logic [OFFSET_BITS-1:0]  pop_pos;

  // Front end: classify each byte (whitespace, newline, dollar, last) and tag
  // it with its wrapping byte offset. Hold the input while the queue is full.
  sdfrbi_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_class  (push_class),
    .q_pos    (push_pos)
  );

  // Two-entry queue decouples byte intake from result back pressure.
  sdfrbi_queue #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_class (push_class),
    .push_pos   (push_pos),
    .full       (q_full),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .pop_class  (pop_class),
    .pop_pos    (pop_pos)
  );

  // Back end: track marker lines and the pending record candidate, count
  // confirmed records, and drop every byte once the stream has ended.
  sdfrbi_back #(
    .OFFSET_BITS      (OFFSET_BITS),
    .BLANK_LINE_LIMIT (BLANK_LINE_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_class   (pop_class),
    .q_pos     (pop_pos),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[sim/sdf_record_boundary_indexer_checker.sv]
// ----------------------------------------------------------------------------
// sdf_record_boundary_indexer_checker
// Watches both request channels of the record boundary indexer, predicts the
// record starts and end-of-stream marks for every accepted byte, and compares
// each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_record_boundary_indexer_checker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire sdfrbi_pkg::in_req_t  in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire sdfrbi_pkg::out_rsp_t out_data,
  output int                        mismatches,
  output int                        awaiting
);
  import sdfrbi_pkg::*;

  // scanner state
  logic [31:0]           scan_pos;
  logic                  line_head;
  int                    dollar_cnt;
  logic                  in_marker_line;
  logic                  cand_open;
  logic [31:0]           cand_off;
  int                    blank_nl;
  logic [COUNT_BITS-1:0] rec_total;
  logic                  scan_done;

  out_rsp_t expected_records[$];
  int       fail_total = 0;

  function automatic logic is_blank(logic [7:0] b);
    return b == SPACE || (b >= TAB && b <= CR);
  endfunction

  task automatic scan_byte(in_req_t req);
    logic [7:0] b;
    logic       hit;
    logic       done;
    logic [31:0] hit_off;
    out_rsp_t   rsp;
    b       = req.data_byte;
    hit     = 1'b0;
    done    = 1'b0;
    hit_off = '0;
    if (scan_done) return;

    // the pending candidate sees the byte before a marker newline reopens it
    if (cand_open) begin
      if (!is_blank(b)) begin
        cand_open = 1'b0;
        hit       = 1'b1;
        hit_off   = cand_off;
        if (rec_total != COUNT_MAX) rec_total++;
      end else if (b == NEWLINE) begin
        blank_nl++;
        if (blank_nl >= BLANK_LINE_LIMIT_DEF) begin
          cand_open = 1'b0;
          done      = 1'b1;
        end
      end
    end

    if (in_marker_line) begin
      if (b == NEWLINE) begin
        in_marker_line = 1'b0;
        line_head      = 1'b1;
        dollar_cnt     = 0;
        cand_open      = 1'b1;
        cand_off       = scan_pos + 32'd1;
        blank_nl       = 0;
      end
    end else if (b == NEWLINE) begin
      line_head  = 1'b1;
      dollar_cnt = 0;
    end else if (line_head && b == DOLLAR) begin
      dollar_cnt++;
      if (dollar_cnt >= int'(MARKER_LEN)) begin
        in_marker_line = 1'b1;
        line_head      = 1'b0;
        dollar_cnt     = 0;
      end
    end else begin
      line_head  = 1'b0;
      dollar_cnt = 0;
    end

    scan_pos = scan_pos + 32'd1;
    if (req.final_byte) done = 1'b1;
    if (done) begin
      scan_done = 1'b1;
      cand_open = 1'b0;
    end

    if (hit || done) begin
      rsp.has_record    = hit;
      rsp.record_offset = hit ? hit_off : '0;
      rsp.record_count  = rec_total;
      rsp.is_end        = done;
      expected_records.insert(expected_records.size(), rsp);
    end
  endtask

  task automatic flag(string what, out_rsp_t exp, out_rsp_t got);
    fail_total++;
    if (fail_total <= 10)
      $display("%s: exp rec=%0b off=%0d cnt=%0d end=%0b, got rec=%0b off=%0d cnt=%0d end=%0b",
               what, exp.has_record, exp.record_offset, exp.record_count, exp.is_end,
               got.has_record, got.record_offset, got.record_count, got.is_end);
  endtask

  always @(posedge clk) begin
    out_rsp_t exp;
    if (!rst_n) begin
      scan_pos       = '0;
      line_head      = 1'b1;
      dollar_cnt     = 0;
      in_marker_line = 1'b0;
      cand_open      = 1'b1;
      cand_off       = '0;
      blank_nl       = 0;
      rec_total      = '0;
      scan_done      = 1'b0;
      expected_records.delete();
    end else begin
      // compare before predicting: a result never leaves in its byte's own cycle
      if (out_valid && !out_stall) begin
        if (expected_records.size() == 0) begin
          flag("unexpected result", '0, out_data);
        end else begin
          exp = expected_records.pop_front();
          if (out_data.has_record !== exp.has_record ||
              out_data.record_offset !== exp.record_offset ||
              out_data.record_count !== exp.record_count ||
              out_data.is_end !== exp.is_end)
            flag("result mismatch", exp, out_data);
        end
      end
      if (in_valid && !in_stall) scan_byte(in_data);
    end
    mismatches <= fail_total;
    awaiting   <= expected_records.size();
  end

endmodule

`default_nettype wire

[sim/sdf_record_boundary_indexer_top_tb.sv]
// ----------------------------------------------------------------------------
// sdf_record_boundary_indexer_top_tb
// Feeds one long structure-data text stream into the record boundary indexer:
// a directed opening, then random records with noise, then one of several
// stream endings and a few bytes past the end. Both channels idle and stall at
// random; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_record_boundary_indexer_top_tb;
  import sdfrbi_pkg::*;

  localparam int TEXT_BYTES   = 1700;    // stop generating records past this
  localparam int HOLD_CYCLES  = 300;     // initial receiver hold-off
  localparam int DRAIN_CYCLES = 8;       // settle time after the last expected result is taken
  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest clean run

  // ways to finish the single stream the run can scan
  typedef enum int {
    END_ON_MARKER_NEWLINE,  // marker newline is the last byte, new candidate dropped
    END_ON_CONFIRM,         // last byte confirms a record
    END_ON_BLANK_LINES,     // too many newlines while a candidate waits
    END_ON_PLAIN_BYTE       // last byte with no candidate pending
  } stream_end_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_rsp_t out_data;
  int       mismatches;
  int       awaiting;
  int       cycles = 0;

  // sender bookkeeping
  int   burst_left;
  logic offer_on;
  int   items_sent;

  // light scan tracker, used only to keep the stream from ending early
  logic g_line_head;
  int   g_dollars;
  logic g_in_marker;
  logic g_cand;
  int   g_blank_nl;

  sdf_record_boundary_indexer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sdf_record_boundary_indexer_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one byte and hold it until the block takes it; close the burst with
  // a random gap when its length runs out.
  task automatic push_byte(logic [7:0] b, logic fin);
    // keep the tracker in step with what the block will see
    if (g_cand) begin
      if (!(b == SPACE || (b >= TAB && b <= CR))) g_cand = 1'b0;
      else if (b == NEWLINE) g_blank_nl++;
    end
    if (g_in_marker) begin
      if (b == NEWLINE) begin
        g_in_marker = 1'b0;
        g_line_head = 1'b1;
        g_dollars   = 0;
        g_cand      = 1'b1;
        g_blank_nl  = 0;
      end
    end else if (b == NEWLINE) begin
      g_line_head = 1'b1;
      g_dollars   = 0;
    end else if (g_line_head && b == DOLLAR) begin
      g_dollars++;
      if (g_dollars >= int'(MARKER_LEN)) begin
        g_in_marker = 1'b1;
        g_line_head = 1'b0;
        g_dollars   = 0;
      end
    end else begin
      g_line_head = 1'b0;
      g_dollars   = 0;
    end

    in_data  <= in_req_t'{data_byte: b, final_byte: fin};
    in_valid <= 1'b1;
    offer_on = 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      offer_on = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long burst, so some stretches run with no idling
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
                                                : $urandom_range(1, 16);
    end
  endtask

  // Send a body byte; swap a newline that would end the stream for a space.
  task automatic put_text(logic [7:0] b);
    logic [7:0] b_out;
    b_out = b;
    if (b == NEWLINE && g_cand && g_blank_nl >= BLANK_LINE_LIMIT_DEF - 1) b_out = SPACE;
    push_byte(b_out, 1'b0);
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put_text(s[i]);
  endtask

  function automatic logic [7:0] pick_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? SPACE : TAB + 8'(r);  // space or 0x09..0x0D
  endfunction

  function automatic logic [7:0] pick_text();
    if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  // One record: leading blank run, a few body lines, usually a marker line.
  task automatic emit_record();
    int n_lines;
    int line_len;
    repeat ($urandom_range(0, 5)) put_text(pick_blank());
    n_lines = $urandom_range(1, 4);
    repeat (n_lines) begin
      line_len = $urandom_range(0, 10);
      // lines that start like a marker but fall short
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) put_text(DOLLAR);
      repeat (line_len) put_text(pick_text());
      if ($urandom_range(0, 5) == 0) put_text(CR);
      put_text(NEWLINE);
    end
    if ($urandom_range(0, 9) != 0) begin
      repeat (4 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)) put_text(DOLLAR);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put_text(pick_text());
      if ($urandom_range(0, 4) == 0) put_text(CR);
      put_text(NEWLINE);
    end
  endtask

  // Close the stream in one of the ways the block treats specially.
  task automatic finish_stream(stream_end_t how);
    // 'x' settles any waiting candidate; the marker then starts at a line head
    put_text("x");
    put_text(NEWLINE);
    repeat (4) put_text(DOLLAR);
    case (how)
      END_ON_MARKER_NEWLINE: begin
        push_byte(NEWLINE, 1'b1);
      end
      END_ON_CONFIRM: begin
        push_byte(NEWLINE, 1'b0);
        push_byte("M", 1'b1);
      end
      END_ON_BLANK_LINES: begin
        push_byte(NEWLINE, 1'b0);
        push_byte(SPACE, 1'b0);
        push_byte(NEWLINE, 1'b0);
        push_byte(TAB, 1'b0);
        push_byte(NEWLINE, 1'b0);
        push_byte(NEWLINE, 1'b0);
        push_byte(NEWLINE, 1'b0);
      end
      default: begin
        push_byte(NEWLINE, 1'b0);
        push_byte("M", 1'b0);
        push_byte("z", 1'b1);
      end
    endcase
  endtask

  // Receiver: hold off long enough to fill the block, then stall by pattern.
  initial begin
    int mode;
    int span;
    int tick;
    out_stall = 1'b1;
    tick      = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // Sender and verdict.
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    offer_on    = 1'b0;
    items_sent  = 0;
    burst_left  = $urandom_range(1, 16);
    g_line_head = 1'b1;
    g_dollars   = 0;
    g_in_marker = 1'b0;
    g_cand      = 1'b1;
    g_blank_nl  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // every whitespace kind before the first record, then NUL confirms offset 0
    put_str(" \t\015\013\014\n");
    put_text(8'h00);
    // five dollars with trailing text still marks a record end
    put_str("\n$$$$$x\n");
    // three blank lines keep the candidate, the byte above CR confirms it
    put_str("\n\n\n");
    put_text(8'h0E);
    // the byte below TAB confirms too; 0xFF is plain body text
    put_str("\n$$$$\n");
    put_text(8'h08);
    put_text(8'hFF);

    while (items_sent < TEXT_BYTES) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(5, 20)) put_text(8'($urandom_range(0, 255)));
      else
        emit_record();
    end

    finish_stream(stream_end_t'($urandom_range(0, 3)));
    // past the end: the block must ignore these
    repeat (8) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if (offer_on) in_valid <= 1'b0;

    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaiting == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hdl/sdfrbi_pkg.sv
hdl/sdfrbi_front.sv
hdl/sdfrbi_queue.sv
hdl/sdfrbi_back.sv
hdl/sdf_record_boundary_indexer_top.sv
sim/sdf_record_boundary_indexer_checker.sv
sim/sdf_record_boundary_indexer_top_tb.sv
